FILE: rtl/core/sab_pkg.sv
// ---------------------------------------------------------------------------
// sab_pkg
// Shared constants, micro-operation codes and status bundle for the
// suffix automaton builder.
// ---------------------------------------------------------------------------
package sab_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_SLOTS  = 2 * MAX_LEN;
  localparam int NODE_W      = $clog2(NODE_SLOTS);
  localparam int NCNT_W      = NODE_W + 1;
  localparam int SLEN_W      = $clog2(MAX_LEN + 1);
  localparam int TRANS_DEPTH = NODE_SLOTS * ALPHABET;
  localparam int TADDR_W     = $clog2(TRANS_DEPTH);
  localparam int SYM_W       = 5;
  localparam int TOTAL_W     = 24;
  localparam int CNT_W       = $clog2(ALPHABET + 1);

  localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(ALPHABET - 1);
  localparam logic [CNT_W-1:0] CPY_LAST = CNT_W'(ALPHABET);

  // micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_INIT,
    OP_NEWZ,
    OP_ZLEN,
    OP_CLRZ,
    OP_W1RD,
    OP_W1CK,
    OP_HV,
    OP_HX,
    OP_HC,
    OP_CL0,
    OP_CL1,
    OP_CL2,
    OP_CL3,
    OP_CPY,
    OP_W2RD,
    OP_W2CK,
    OP_FIN,
    OP_SKIP
  } op_t;

  typedef struct packed {
    logic restart;
    logic full;
    logic sym_bad;
    logic t_zero;
    logic t_eq_x;
    logic v_root;
    logic len_eq;
    logic clr_last;
    logic cpy_last;
    logic out_busy;
  } status_t;

  // node index times alphabet size, as a table base address
  function automatic logic [TADDR_W-1:0] node_base(input logic [NODE_W-1:0] n);
    node_base = TADDR_W'(n) * TADDR_W'(ALPHABET);
  endfunction

endpackage

FILE: rtl/core/sab_if.sv
// ---------------------------------------------------------------------------
// sab_if
// Valid/ready channels of the suffix automaton builder.
// ---------------------------------------------------------------------------
interface sab_in_if;
  import sab_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             restart;
  modport source (output valid, symbol, restart, input ready);
  modport sink   (input valid, symbol, restart, output ready);
endinterface

interface sab_out_if;
  import sab_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] distinct_count;
  logic               store_full;
  modport source (output valid, distinct_count, store_full, input ready);
  modport sink   (input valid, distinct_count, store_full, output ready);
endinterface

FILE: rtl/core/sab_ram.sv
// ---------------------------------------------------------------------------
// sab_ram
// Generic memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sab_dp.sv
// ---------------------------------------------------------------------------
// sab_dp
// Datapath: node tables, walk registers, counters and result register.
// ---------------------------------------------------------------------------
module sab_dp
  import sab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  op_t      op,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic     in_restart,
  output status_t  st,
  sab_out_if.source res
);

  logic [SYM_W-1:0]   sym;
  logic               rstf;
  logic [NODE_W-1:0]  z, v, x, y, last;
  logic [NODE_W-1:0]  lenz, lenv1, shortz;
  logic [NCNT_W-1:0]  node_count;
  logic [SLEN_W-1:0]  slen;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   cnt;

  logic               t_we;
  logic [TADDR_W-1:0] t_wa, t_ra;
  logic [NODE_W-1:0]  t_wd, t_rd;
  logic               l_we;
  logic [NODE_W-1:0]  l_wa, l_ra, l_wd, l_rd;
  logic               k_we;
  logic [NODE_W-1:0]  k_wa, k_ra, k_wd, k_rd;
  logic [TADDR_W-1:0] vslot;
  logic [NODE_W-1:0]  nnode;

  assign vslot = node_base(v) + TADDR_W'(sym);
  assign nnode = node_count[NODE_W-1:0];

  sab_ram #(.WIDTH(NODE_W), .DEPTH(TRANS_DEPTH)) u_trans (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  sab_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_len (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  sab_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_link (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

  // memory port steering
  always_comb begin
    t_we = 1'b0; t_wa = vslot; t_wd = '0; t_ra = vslot;
    l_we = 1'b0; l_wa = '0;    l_wd = '0; l_ra = v;
    k_we = 1'b0; k_wa = '0;    k_wd = '0; k_ra = v;
    case (op)
      OP_INIT: begin
        t_we = 1'b1; t_wa = TADDR_W'(cnt);
        l_we = 1'b1;
        k_we = 1'b1;
      end
      OP_NEWZ: l_ra = last;
      OP_ZLEN: begin
        l_we = 1'b1; l_wa = z; l_wd = l_rd + NODE_W'(1);
        k_we = 1'b1; k_wa = z;
      end
      OP_CLRZ: begin
        t_we = 1'b1; t_wa = node_base(z) + TADDR_W'(cnt);
      end
      OP_W1CK: begin
        t_we = (t_rd == '0); t_wd = z;
      end
      OP_HX: l_ra = x;
      OP_HC: begin
        k_we = (l_rd == lenv1); k_wa = z; k_wd = x;
      end
      OP_CL0: begin
        l_we = 1'b1; l_wa = nnode; l_wd = lenv1;
        k_ra = x;
      end
      OP_CL1: begin
        k_we = 1'b1; k_wa = y; k_wd = k_rd;
      end
      OP_CL2: begin
        k_we = 1'b1; k_wa = x; k_wd = y;
      end
      OP_CL3: begin
        k_we = 1'b1; k_wa = z; k_wd = y;
      end
      OP_CPY: begin
        t_ra = node_base(x) + TADDR_W'(cnt);
        t_we = (cnt != '0);
        t_wa = node_base(y) + TADDR_W'(cnt) - TADDR_W'(1);
        t_wd = t_rd;
      end
      OP_W2CK: begin
        t_we = (t_rd == x); t_wd = y;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    st.restart  = rstf;
    st.full     = (slen >= SLEN_W'(MAX_LEN));
    st.sym_bad  = (sym >= SYM_W'(ALPHABET));
    st.t_zero   = (t_rd == '0);
    st.t_eq_x   = (t_rd == x);
    st.v_root   = (v == '0);
    st.len_eq   = (l_rd == lenv1);
    st.clr_last = (cnt == CLR_LAST);
    st.cpy_last = (cnt == CPY_LAST);
    st.out_busy = res.valid && !res.ready;
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NCNT_W'(1);
      last       <= '0;
      slen       <= '0;
      total      <= '0;
      cnt        <= '0;
      res.valid  <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (res.valid && res.ready && op != OP_FIN && op != OP_SKIP) begin
        res.valid <= 1'b0;
      end
      case (op)
        OP_LATCH: begin
          sym  <= in_symbol;
          rstf <= in_restart;
          if (in_restart) begin
            node_count <= NCNT_W'(1);
            last       <= '0;
            slen       <= '0;
            total      <= '0;
          end
        end
        OP_INIT: begin
          rstf <= 1'b0;
          cnt  <= (cnt == CLR_LAST) ? '0 : cnt + CNT_W'(1);
        end
        OP_NEWZ: begin
          z          <= nnode;
          node_count <= node_count + NCNT_W'(1);
        end
        OP_ZLEN: begin
          lenz <= l_rd + NODE_W'(1);
          v    <= last;
        end
        OP_CLRZ: cnt <= (cnt == CLR_LAST) ? '0 : cnt + CNT_W'(1);
        OP_W1CK: begin
          if (t_rd != '0) begin
            x <= t_rd;
          end else if (v == '0) begin
            shortz <= NODE_W'(1);
          end else begin
            v <= k_rd;
          end
        end
        OP_HX: lenv1 <= l_rd + NODE_W'(1);
        OP_HC: shortz <= l_rd + NODE_W'(1);
        OP_CL0: begin
          y          <= nnode;
          node_count <= node_count + NCNT_W'(1);
        end
        OP_CL3: shortz <= lenv1 + NODE_W'(1);
        OP_CPY: cnt <= (cnt == CPY_LAST) ? '0 : cnt + CNT_W'(1);
        OP_W2CK: begin
          if (t_rd == x && v != '0) begin
            v <= k_rd;
          end
        end
        OP_FIN: begin
          total              <= total + TOTAL_W'(lenz - shortz + NODE_W'(1));
          res.distinct_count <= total + TOTAL_W'(lenz - shortz + NODE_W'(1));
          res.store_full     <= 1'b0;
          res.valid          <= 1'b1;
          last               <= z;
          slen               <= slen + SLEN_W'(1);
        end
        OP_SKIP: begin
          res.distinct_count <= total;
          res.store_full     <= (slen >= SLEN_W'(MAX_LEN));
          res.valid          <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/sab_ctrl.sv
// ---------------------------------------------------------------------------
// sab_ctrl
// Controller: sequences table clearing, suffix-link walks, node split and
// transition copy for each symbol.
// ---------------------------------------------------------------------------
module sab_ctrl
  import sab_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output op_t     op
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CHK, S_NEWZ, S_ZLEN, S_CLRZ, S_W1RD, S_W1CK,
    S_HV, S_HX, S_HC, S_CL0, S_CL1, S_CL2, S_CL3, S_CPY,
    S_W2RD, S_W2CK, S_FIN, S_SKIP
  } state_t;

  state_t state;
  logic   pend;

  assign in_ready = (state == S_IDLE);

  // operation per state
  always_comb begin
    unique case (state)
      S_INIT:  op = OP_INIT;
      S_IDLE:  op = in_valid ? OP_LATCH : OP_NONE;
      S_CHK:   op = OP_NONE;
      S_NEWZ:  op = OP_NEWZ;
      S_ZLEN:  op = OP_ZLEN;
      S_CLRZ:  op = OP_CLRZ;
      S_W1RD:  op = OP_W1RD;
      S_W1CK:  op = OP_W1CK;
      S_HV:    op = OP_HV;
      S_HX:    op = OP_HX;
      S_HC:    op = OP_HC;
      S_CL0:   op = OP_CL0;
      S_CL1:   op = OP_CL1;
      S_CL2:   op = OP_CL2;
      S_CL3:   op = OP_CL3;
      S_CPY:   op = OP_CPY;
      S_W2RD:  op = OP_W2RD;
      S_W2CK:  op = OP_W2CK;
      S_FIN:   op = st.out_busy ? OP_NONE : OP_FIN;
      S_SKIP:  op = st.out_busy ? OP_NONE : OP_SKIP;
      default: op = OP_NONE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: if (st.clr_last) begin
          state <= pend ? S_CHK : S_IDLE;
          pend  <= 1'b0;
        end
        S_IDLE: if (in_valid) begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (st.restart) begin
            state <= S_INIT;
            pend  <= 1'b1;
          end else if (st.full || st.sym_bad) begin
            state <= S_SKIP;
          end else begin
            state <= S_NEWZ;
          end
        end
        S_NEWZ: state <= S_ZLEN;
        S_ZLEN: state <= S_CLRZ;
        S_CLRZ: if (st.clr_last) state <= S_W1RD;
        S_W1RD: state <= S_W1CK;
        S_W1CK: begin
          if (!st.t_zero)     state <= S_HV;
          else if (st.v_root) state <= S_FIN;
          else                state <= S_W1RD;
        end
        S_HV:   state <= S_HX;
        S_HX:   state <= S_HC;
        S_HC:   state <= st.len_eq ? S_FIN : S_CL0;
        S_CL0:  state <= S_CL1;
        S_CL1:  state <= S_CL2;
        S_CL2:  state <= S_CL3;
        S_CL3:  state <= S_CPY;
        S_CPY:  if (st.cpy_last) state <= S_W2RD;
        S_W2RD: state <= S_W2CK;
        S_W2CK: state <= (st.t_eq_x && !st.v_root) ? S_W2RD : S_FIN;
        S_FIN:  if (!st.out_busy) state <= S_IDLE;
        S_SKIP: if (!st.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/suffix_automaton_builder_core.sv
// ---------------------------------------------------------------------------
// suffix_automaton_builder_core
// Online suffix automaton construction; each symbol request returns the
// running count of distinct non-empty substrings.
// ---------------------------------------------------------------------------
// channel   dir  payload                       handshake
// symbols   in   symbol[4:0], restart          valid/ready
// results   out  distinct_count[23:0], full    valid/ready
//
// after reset the root transition row is cleared, no request taken
// a restart request repeats that clear before its symbol
// a symbol clears the transition row of its new node, then walks suffix links;
// a hit checks the length of the target node, and a split clones it, copies its
// transition row and redirects the links that still point at the old node
// a result waits in its output register; the next request is taken meanwhile
// ---------------------------------------------------------------------------
module suffix_automaton_builder_core
  import sab_pkg::*;
(
  input logic       clk,
  input logic       rst,
  sab_in_if.sink    symbols,
  sab_out_if.source results
);

  op_t     op;
  status_t st;

  sab_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (symbols.valid),
    .in_ready (symbols.ready),
    .st, .op
  );

  sab_dp u_dp (
    .clk, .rst, .op,
    .in_symbol  (symbols.symbol),
    .in_restart (symbols.restart),
    .st,
    .res        (results)
  );

endmodule

FILE: rtl/core/sab_checker.sv
// ---------------------------------------------------------------------------
// sab_checker
// Port-level checks of the suffix automaton builder.
// ---------------------------------------------------------------------------
module sab_checker
  import sab_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TOTAL_W-1:0] distinct_count
);

  // root clear follows reset
  a_rst_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("ready right after reset");

  // one request at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted back to back");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(distinct_count)))
    else $error("stalled result changed");

endmodule

bind suffix_automaton_builder_core sab_checker u_sab_checker (
  .clk, .rst,
  .in_valid       (symbols.valid),
  .in_ready       (symbols.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .distinct_count (results.distinct_count)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives symbol requests with random restarts and idle gaps into the suffix
// automaton builder and checks each distinct-substring count against an
// online automaton model kept in the testbench.
// ---------------------------------------------------------------------------
module testbench;
  import sab_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } sym_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] count;
    logic               full;
  } count_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sab_in_if  symbols ();
  sab_out_if results ();

  suffix_automaton_builder_core dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols.sink),
    .results (results.source)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // automaton model state
  int unsigned sam_next [NODE_SLOTS][ALPHABET];
  int unsigned sam_maxlen [NODE_SLOTS];
  int unsigned sam_minlen [NODE_SLOTS];
  int unsigned sam_link [NODE_SLOTS];
  int unsigned sam_nodes;
  int unsigned sam_tail;
  int unsigned sam_strlen;
  longint unsigned sam_total;

  sym_req_t   pending_reqs [$];
  count_rsp_t expected_counts [$];
  int         error_count = 0;
  bit         in_acc = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;

  function automatic int unsigned sam_alloc(input int unsigned len);
    int unsigned n;
    n = sam_nodes % NODE_SLOTS;
    sam_nodes++;
    sam_maxlen[n] = len;
    sam_minlen[n] = 0;
    sam_link[n] = 0;
    for (int k = 0; k < ALPHABET; k++) sam_next[n][k] = 0;
    return n;
  endfunction

  function automatic void sam_clear();
    sam_nodes = 0;
    void'(sam_alloc(0));
    sam_tail = 0;
    sam_strlen = 0;
    sam_total = 0;
  endfunction

  function automatic void sam_extend(input int unsigned c);
    int unsigned z, v, x, y, w;
    bit hit;
    z = sam_alloc(sam_maxlen[sam_tail] + 1);
    v = sam_tail;
    hit = 1'b1;
    forever begin
      if (sam_next[v][c] != 0) break;
      sam_next[v][c] = z;
      if (v == 0) begin
        hit = 1'b0;
        break;
      end
      v = sam_link[v];
    end
    if (!hit) begin
      sam_link[z] = 0;
      sam_minlen[z] = 1;
    end else begin
      x = sam_next[v][c];
      if (sam_maxlen[x] == sam_maxlen[v] + 1) begin
        sam_link[z] = x;
        sam_minlen[z] = sam_maxlen[x] + 1;
      end else begin
        // split: clone x into y
        y = sam_alloc(sam_maxlen[v] + 1);
        for (int k = 0; k < ALPHABET; k++) sam_next[y][k] = sam_next[x][k];
        sam_link[y] = sam_link[x];
        sam_minlen[y] = sam_maxlen[sam_link[x]] + 1;
        sam_link[x] = y;
        sam_minlen[x] = sam_maxlen[y] + 1;
        sam_link[z] = y;
        sam_minlen[z] = sam_maxlen[y] + 1;
        w = v;
        forever begin
          if (sam_next[w][c] != x) break;
          sam_next[w][c] = y;
          if (w == 0) break;
          w = sam_link[w];
        end
      end
    end
    sam_total += sam_maxlen[z] - sam_minlen[z] + 1;
    sam_tail = z;
    sam_strlen++;
  endfunction

  // predicted count for one request
  function automatic count_rsp_t predict_count(input sym_req_t r);
    count_rsp_t p;
    p.full = 1'b0;
    if (r.restart) sam_clear();
    if (sam_strlen >= MAX_LEN) p.full = 1'b1;
    else if (r.symbol < ALPHABET) sam_extend(r.symbol);
    p.count = sam_total[TOTAL_W-1:0];
    return p;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic queue_req(input bit rs, input int sym);
    sym_req_t r;
    r.restart = rs;
    r.symbol = SYM_W'(sym);
    pending_reqs.push_back(r);
  endtask

  // driver: requests change at the falling edge
  initial begin
    symbols.valid = 1'b0;
    symbols.symbol = '0;
    symbols.restart = 1'b0;
  end

  // request acceptance, sampled at the rising edge
  always @(posedge clk) begin
    in_acc <= !rst && symbols.valid && symbols.ready;
  end

  always @(negedge clk) begin
    sym_req_t r;
    if (!rst) begin
      if (in_acc) begin
        expected_counts.push_back(predict_count({symbols.symbol, symbols.restart}));
        in_gap = pick_gap();
      end else if (!symbols.valid && in_gap > 0) begin
        in_gap--;
      end
      if ((in_acc || !symbols.valid) && in_gap == 0 && pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        symbols.valid <= 1'b1;
        symbols.symbol <= r.symbol;
        symbols.restart <= r.restart;
      end else if (in_acc) begin
        symbols.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  initial results.ready = 1'b0;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
      out_gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d", results.distinct_count));
      end else begin
        count_rsp_t e;
        e = expected_counts.pop_front();
        if (results.distinct_count !== e.count)
          report_mismatch($sformatf("count got %0d want %0d",
                                    results.distinct_count, e.count));
        if (results.store_full !== e.full)
          report_mismatch($sformatf("store_full got %0b want %0b",
                                    results.store_full, e.full));
      end
    end
  end

  // stimulus
  initial begin
    int n_rand;
    int word_len;
    sam_clear();
    // directed: extremes, out-of-range symbols, repeats that force splits
    queue_req(1'b0, 0);
    queue_req(1'b0, 25);
    queue_req(1'b0, 0);
    queue_req(1'b0, 0);
    queue_req(1'b0, 26);
    queue_req(1'b0, 31);
    queue_req(1'b0, 25);
    queue_req(1'b1, 1);
    queue_req(1'b0, 1);
    queue_req(1'b0, 0);
    queue_req(1'b0, 1);
    queue_req(1'b0, 1);
    queue_req(1'b0, 0);
    queue_req(1'b1, 31);
    queue_req(1'b0, 16);
    queue_req(1'b1, 25);
    // out-of-range symbol, then a restart
    queue_req(1'b0, 31);
    queue_req(1'b1, 3);
    // random: mostly small alphabets to provoke splits, some noise
    n_rand = 0;
    while (n_rand < 1830) begin
      word_len = $urandom_range(1, 60);
      for (int i = 0; i < word_len; i++) begin
        int s;
        case ($urandom_range(0, 9))
          0: s = $urandom_range(0, 31);
          1, 2: s = $urandom_range(0, 25);
          default: s = $urandom_range(0, 3);
        endcase
        queue_req(i == 0 && $urandom_range(0, 1), s);
        n_rand++;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !symbols.valid);
    wait (expected_counts.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("** suffix_automaton_builder_core: PASSED **");
    end else begin
      $display("** suffix_automaton_builder_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("** suffix_automaton_builder_core: FAILED **");
    $finish;
  end

endmodule
